@@ design/ldpchd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldpchd_pkg
// Shared types, code constants and node functions for the hard-decision
// LDPC decoder.
// ----------------------------------------------------------------------------
package ldpchd_pkg;

  localparam int CODE_LENGTH = 12;
  localparam int CHECK_COUNT = 9;
  localparam int ITER_W      = 7;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  localparam logic [ITER_W-1:0] ITER_RESET = 7'd100;

  typedef logic [CODE_LENGTH-1:0]                  word_t;
  typedef logic [CHECK_COUNT-1:0][CODE_LENGTH-1:0] msg_t;

  // parity-check matrix, row r bit i set where check r sees variable i
  localparam msg_t H = {
    12'h90C, 12'h2A2, 12'h249, 12'h512, 12'h8C4,
    12'hC24, 12'h152, 12'h419, 12'h2A1
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic finish;    // this pass is the last one
    logic out_free;  // output register can take a word
  } status_t;

  // check nodes: extrinsic XOR back to each neighbour
  function automatic msg_t check_pass(input msg_t tc);
    msg_t tv;
    logic par;
    for (int r = 0; r < CHECK_COUNT; r++) begin
      par   = ^(tc[r] & H[r]);
      tv[r] = ({CODE_LENGTH{par}} ^ tc[r]) & H[r];
    end
    return tv;
  endfunction

  function automatic logic all_even(input msg_t tc);
    logic ok;
    ok = 1'b1;
    for (int r = 0; r < CHECK_COUNT; r++) begin
      if (^(tc[r] & H[r])) ok = 1'b0;
    end
    return ok;
  endfunction

  // variable nodes: majority of channel bit and the two other checks
  function automatic msg_t var_update(input word_t chan, input msg_t tv);
    msg_t tc;
    logic [1:0] cnt;
    tc = '0;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      for (int r = 0; r < CHECK_COUNT; r++) begin
        if (H[r][i]) begin
          cnt = {1'b0, chan[i]};
          for (int r2 = 0; r2 < CHECK_COUNT; r2++) begin
            if (r2 != r && H[r2][i]) cnt = cnt + {1'b0, tv[r2][i]};
          end
          tc[r][i] = (cnt >= 2'd2);
        end
      end
    end
    return tc;
  endfunction

  // final decision: at least three of four ones, ties to 0
  function automatic word_t decide(input word_t chan, input msg_t tv);
    word_t dec;
    logic [2:0] cnt;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      cnt = {2'b00, chan[i]};
      for (int r = 0; r < CHECK_COUNT; r++) begin
        if (H[r][i]) cnt = cnt + {2'b00, tv[r][i]};
      end
      dec[i] = (cnt >= 3'd3);
    end
    return dec;
  endfunction

endpackage

@@ design/ldpchd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldpchd_ctrl
// Sequencer: load word, one decoding pass a cycle, then hand the result on.
// ----------------------------------------------------------------------------
module ldpchd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  ldpchd_pkg::status_t status,
  output ldpchd_pkg::cmd_t    cmd
);

  ldpchd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ldpchd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ldpchd_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = ldpchd_pkg::ST_RUN;
      end
      ldpchd_pkg::ST_RUN: begin
        if (status.finish) state_nxt = ldpchd_pkg::ST_EMIT;
      end
      ldpchd_pkg::ST_EMIT: begin
        if (status.out_free) state_nxt = ldpchd_pkg::ST_IDLE;
      end
      default: state_nxt = ldpchd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      ldpchd_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ldpchd_pkg::ST_RUN: begin
        cmd.step = 1'b1;
      end
      ldpchd_pkg::ST_EMIT: begin
        cmd.emit = status.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

@@ design/ldpchd_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldpchd_datapath
// Message registers, parallel check/variable node logic, iteration limit
// register and the output word register.
// ----------------------------------------------------------------------------
module ldpchd_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [ldpchd_pkg::ITER_W-1:0]          cfg_wr_data,
  input  ldpchd_pkg::word_t                      word_in,
  input  ldpchd_pkg::cmd_t                       cmd,
  output ldpchd_pkg::status_t                    status,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [ldpchd_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  logic [ldpchd_pkg::ITER_W-1:0] max_iter_r;
  logic [ldpchd_pkg::ITER_W-1:0] limit;
  logic [ldpchd_pkg::ITER_W-1:0] iter_r;
  logic [ldpchd_pkg::ITER_W-1:0] iter_inc;
  ldpchd_pkg::word_t             chan_r;
  ldpchd_pkg::msg_t              to_chk_r;
  ldpchd_pkg::msg_t              to_var_r;
  ldpchd_pkg::msg_t              to_var_nxt;
  logic                          even;
  logic                          last;
  logic                          sat_r;
  logic                          out_valid_r;
  logic [ldpchd_pkg::OUT_TDATA_W-1:0] out_data_r;

  assign limit      = (max_iter_r == '0) ? ldpchd_pkg::ITER_W'(1) : max_iter_r;
  assign iter_inc   = iter_r + ldpchd_pkg::ITER_W'(1);
  assign to_var_nxt = ldpchd_pkg::check_pass(to_chk_r);
  assign even       = ldpchd_pkg::all_even(to_chk_r);
  assign last       = (iter_inc == limit);

  assign status.finish   = even | last;
  assign status.out_free = ~out_valid_r | out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= ldpchd_pkg::ITER_RESET;
    end else if (cfg_wr_en) begin
      max_iter_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      chan_r <= word_in;
      iter_r <= '0;
      for (int r = 0; r < ldpchd_pkg::CHECK_COUNT; r++) begin
        to_chk_r[r] <= word_in & ldpchd_pkg::H[r];
      end
    end else if (cmd.step) begin
      iter_r   <= iter_inc;
      to_var_r <= to_var_nxt;
      sat_r    <= even;
      // no variable update once converged or on the final pass
      if (!even && !last) begin
        to_chk_r <= ldpchd_pkg::var_update(chan_r, to_var_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= {4'b0000, iter_r, sat_r, ldpchd_pkg::decide(chan_r, to_var_r)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ design/ldpc_hard_decision_decoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldpc_hard_decision_decoder_top
// Hard-decision message-passing decoder for a fixed 9x12 LDPC code.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one 12-bit received word per accepted word (stream handshake).
//   out_* : one result word per input: decoded word, parity flag and the
//           number of check passes used.
//   cfg_* : cfg_wr_en writes the iteration limit (0 acts as 1). The user must
//           write it only while the decoder is idle; it is not enforced.
// Timing: the word is loaded, then one pass per cycle runs (all node logic in
//   parallel) until all checks are even or the limit is reached, and then
//   the result is registered; the number of passes N is at most the limit.
//   Only one word is decoded at a time; in_tready is high while idle.
// Reset: rst_n low clears the sequencer and output valid and sets the limit
//   to 100.
// Stall: a finished result waits in the output register; a new word can be
//   taken and decoded meanwhile and holds at the end until the slot frees.
// ----------------------------------------------------------------------------
module ldpc_hard_decision_decoder_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [ldpchd_pkg::IN_TDATA_W-1:0]     in_tdata,   // [11:0] received_word
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [ldpchd_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [11:0] decoded_word,
                                                            // [12] parity_satisfied,
                                                            // [19:13] iterations_used
  input  logic                                 cfg_wr_en,
  input  logic [ldpchd_pkg::ITER_W-1:0]         cfg_wr_data
);

  ldpchd_pkg::cmd_t    cmd;
  ldpchd_pkg::status_t status;

  ldpchd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  ldpchd_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .word_in     (in_tdata[ldpchd_pkg::CODE_LENGTH-1:0]),
    .cmd         (cmd),
    .status      (status),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

@@ dv/ldpchd_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldpchd_result_checker
// Watches the decoder's input, result and limit-write ports. Every accepted
// input word is decoded here with a local copy of the iteration limit, and
// every accepted result word is compared field by field with the oldest
// decode still pending.
// ----------------------------------------------------------------------------
module ldpchd_result_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [ldpchd_pkg::IN_TDATA_W-1:0]  in_tdata,   // [11:0] received_word
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [ldpchd_pkg::OUT_TDATA_W-1:0] out_tdata,  // [11:0] decoded_word,
                                                         // [12] parity_satisfied,
                                                         // [19:13] iterations_used
  input  logic                              cfg_wr_en,
  input  logic [ldpchd_pkg::ITER_W-1:0]      cfg_wr_data,
  output int unsigned                       fail_count,
  output int unsigned                       outstanding
);

  localparam int NUM_VARS   = 12;
  localparam int NUM_CHECKS = 9;

  // row r: bit i set where check r sees variable i
  localparam logic [NUM_VARS-1:0] CHECK_ROWS [NUM_CHECKS] = '{
    12'h2A1, 12'h419, 12'h152, 12'hC24, 12'h8C4,
    12'h512, 12'h249, 12'h2A2, 12'h90C
  };

  typedef struct packed {
    logic [NUM_VARS-1:0] decoded;
    logic                converged;
    logic [6:0]          passes;
  } decode_result_t;

  decode_result_t     pending_decodes [$];
  logic [6:0]         iter_limit;

  function automatic decode_result_t gallager_decode(input logic [NUM_VARS-1:0] chan,
                                                     input logic [6:0] cap);
    logic [NUM_VARS-1:0] var_to_chk [NUM_CHECKS];
    logic [NUM_VARS-1:0] chk_to_var [NUM_CHECKS];
    int unsigned         limit;
    int unsigned         pass_cnt;
    int unsigned         even_cnt;
    int unsigned         ones;
    logic                par;
    logic                settled;
    decode_result_t      res;
    limit    = (cap == 7'd0) ? 1 : int'(cap);
    pass_cnt = 0;
    settled  = 1'b0;
    res      = '0;
    for (int r = 0; r < NUM_CHECKS; r++) begin
      var_to_chk[r] = chan & CHECK_ROWS[r];
      chk_to_var[r] = '0;
    end
    while (!settled && pass_cnt < limit) begin
      pass_cnt++;
      even_cnt = 0;
      for (int r = 0; r < NUM_CHECKS; r++) begin
        par = ^(var_to_chk[r] & CHECK_ROWS[r]);
        if (!par) even_cnt++;
        chk_to_var[r] = (var_to_chk[r] ^ {NUM_VARS{par}}) & CHECK_ROWS[r];
      end
      if (even_cnt == NUM_CHECKS) begin
        settled = 1'b1;
      end else if (pass_cnt != limit) begin
        // each edge: majority of channel bit and the other two checks
        for (int i = 0; i < NUM_VARS; i++) begin
          for (int r = 0; r < NUM_CHECKS; r++) begin
            if (CHECK_ROWS[r][i]) begin
              ones = chan[i];
              for (int k = 0; k < NUM_CHECKS; k++) begin
                if (k != r && CHECK_ROWS[k][i]) ones += chk_to_var[k][i];
              end
              var_to_chk[r][i] = (ones >= 2);
            end
          end
        end
      end
    end
    // four votes, ties fall to zero
    for (int i = 0; i < NUM_VARS; i++) begin
      ones = chan[i];
      for (int r = 0; r < NUM_CHECKS; r++) begin
        if (CHECK_ROWS[r][i]) ones += chk_to_var[r][i];
      end
      res.decoded[i] = (ones >= 3);
    end
    res.converged = settled;
    res.passes    = pass_cnt[6:0];
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    decode_result_t want;
    if (!rst_n) begin
      iter_limit = ldpchd_pkg::ITER_RESET;
      pending_decodes.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) iter_limit = cfg_wr_data;
      if (out_tvalid && out_tready) begin
        if (pending_decodes.size() == 0) begin
          $error("result word with nothing pending: %h", out_tdata);
          fail_count++;
        end else begin
          want = pending_decodes.pop_front();
          if (out_tdata[11:0] !== want.decoded) begin
            $error("decoded_word: expected %h, got %h", want.decoded, out_tdata[11:0]);
            fail_count++;
          end
          if (out_tdata[12] !== want.converged) begin
            $error("parity_satisfied: expected %b, got %b", want.converged, out_tdata[12]);
            fail_count++;
          end
          if (out_tdata[19:13] !== want.passes) begin
            $error("iterations_used: expected %0d, got %0d", want.passes, out_tdata[19:13]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        pending_decodes.push_back(gallager_decode(in_tdata[11:0], iter_limit));
    end
    outstanding = pending_decodes.size();
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the hard-decision LDPC decoder with directed words and then random
// phases under several iteration limits (zero, one, the maximum among
// them), with random gaps on both sides and one long output hold-off. The
// checker beside the decoder reports failures; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          PHASES      = 8;
  localparam int          PHASE_WORDS = 130;
  localparam int          HOLD_AT     = 300;
  localparam int          HOLD_CYCLES = 400;
  localparam int          TAIL_CYCLES = 140;
  localparam int unsigned CYCLE_LIMIT = 800_000;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_tvalid;
  logic                               in_tready;
  logic [ldpchd_pkg::IN_TDATA_W-1:0]  in_tdata;   // [11:0] received_word
  logic                               out_tvalid;
  logic                               out_tready;
  logic [ldpchd_pkg::OUT_TDATA_W-1:0] out_tdata;  // [11:0] decoded_word,
                                                  // [12] parity_satisfied,
                                                  // [19:13] iterations_used
  logic                               cfg_wr_en;
  logic [ldpchd_pkg::ITER_W-1:0]      cfg_wr_data;
  int unsigned                        fail_count;
  int unsigned                        outstanding;
  logic                               in_fast = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  ldpc_hard_decision_decoder_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  ldpchd_result_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // mostly near-codeword patterns so that decoding runs a few passes
  function automatic ldpchd_pkg::word_t draw_word();
    ldpchd_pkg::word_t w;
    int unsigned       flips;
    if ($urandom_range(0, 9) < 4) begin
      w = ldpchd_pkg::word_t'($urandom_range(0, 4095));
    end else begin
      w     = $urandom_range(0, 1) ? '1 : '0;
      flips = $urandom_range(1, 3);
      repeat (flips) w[$urandom_range(0, ldpchd_pkg::CODE_LENGTH-1)] ^= 1'b1;
    end
    return w;
  endfunction

  task automatic send_word(input ldpchd_pkg::word_t w);
    int unsigned gap;
    gap = in_fast ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(ldpchd_pkg::IN_TDATA_W-ldpchd_pkg::CODE_LENGTH){1'b0}}, w};
    do @(posedge clk); while (!(in_tvalid && in_tready));
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_limit(input logic [ldpchd_pkg::ITER_W-1:0] cap);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // stimulus
  initial begin : stimulus
    ldpchd_pkg::word_t directed [$];
    logic [6:0]        caps [PHASES];
    logic [6:0]        cap;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    caps = '{7'd1, 7'd127, 7'd0, 7'd2, 7'd3, 7'd100, 7'd64, 7'd20};
    directed = '{12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'hFFE, 12'h7FF, 12'h003,
                 12'h0C0, 12'hF0F};
    for (int i = 0; i < ldpchd_pkg::CODE_LENGTH; i++)
      directed.push_back(ldpchd_pkg::word_t'(1) << i);
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // default limit first
    foreach (directed[k]) send_word(directed[k]);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      cap = (p == 6) ? 7'($urandom_range(4, 126)) : caps[p];
      write_limit(cap);
      in_fast = ($urandom_range(0, 3) == 0);
      // a few hand-picked words under the extreme limits
      if (cap == 7'd0 || cap == 7'd127) begin
        send_word(12'h000);
        send_word(12'hFFF);
        send_word(12'h001);
        send_word(12'hAAA);
      end
      for (int n = 0; n < PHASE_WORDS; n++) send_word(draw_word());
      drain();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("ldpc_hard_decision_decoder_top: match");
    end else begin
      $display("ldpc_hard_decision_decoder_top: mismatch");
    end
    $finish;
  end

  // result side: random back-pressure and one long hold-off
  initial begin : sink
    int unsigned hold;
    int unsigned taken;
    logic        out_fast;
    taken      = 0;
    out_fast   = 1'b0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (taken % 64 == 0) out_fast = ($urandom_range(0, 3) == 0);
      hold = out_fast ? 0 : $urandom_range(0, 7);
      if (taken == HOLD_AT) hold = HOLD_CYCLES;
      repeat (hold) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      taken++;
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("ldpc_hard_decision_decoder_top: mismatch");
    $finish;
  end

endmodule
